// ===== design/bcsl_pkg.sv =====
// Shared types, constants and the commutation table for the BLDC
// commutation and speed loop unit. No dependencies.
package bcsl_pkg;

  // Event kinds carried by one input item
  typedef enum logic [1:0] {
    REQ_TACHO = 2'd0,
    REQ_HALL  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Phase select codes
  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_A    = 2'd1;
  localparam logic [1:0] PHASE_B    = 2'd2;
  localparam logic [1:0] PHASE_C    = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]         TARGET_RST = 8'd80;
  localparam logic signed [15:0] GAIN_P_RST = 16'sd2867;
  localparam logic signed [15:0] GAIN_I_RST = 16'sd1638;
  localparam logic signed [15:0] GAIN_D_RST = 16'sd16;

  localparam int unsigned ERR_W     = 17;
  localparam int unsigned PROD_W    = 33;
  localparam int unsigned SUM_W     = 35;
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned FRAC_MASK = (1 << FRAC_BITS) - 1;

  localparam logic [7:0]  DUTY_MAX   = 8'd255;
  localparam logic [15:0] HALL_WRAP  = 16'd60000;
  localparam logic [3:0]  STALL_LAST = 4'd9;

  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic [7:0]         target;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic               direction;
  } cfg_t;

  // Event stage to duty stage: PID products plus the drive snapshot
  typedef struct packed {
    logic       tick;
    prod_t      prod_p;
    prod_t      prod_i;
    prod_t      prod_d;
    logic [1:0] high;
    logic [1:0] low;
    logic       stall;
  } pid_t;

  typedef struct packed {
    logic       keep;
    logic [1:0] high;
    logic [1:0] low;
  } drive_t;

  function automatic drive_t drive_lookup(input logic dir, input logic [2:0] code);
    drive_t r;
    r = '{keep: 1'b1, high: PHASE_NONE, low: PHASE_NONE};
    unique case (code)
      3'd1: r = dir ? '{1'b0, PHASE_C, PHASE_A} : '{1'b0, PHASE_A, PHASE_C};
      3'd2: r = dir ? '{1'b0, PHASE_B, PHASE_C} : '{1'b0, PHASE_C, PHASE_B};
      3'd3: r = dir ? '{1'b0, PHASE_B, PHASE_A} : '{1'b0, PHASE_A, PHASE_B};
      3'd4: r = dir ? '{1'b0, PHASE_A, PHASE_B} : '{1'b0, PHASE_B, PHASE_A};
      3'd5: r = dir ? '{1'b0, PHASE_C, PHASE_B} : '{1'b0, PHASE_B, PHASE_C};
      3'd6: r = dir ? '{1'b0, PHASE_A, PHASE_C} : '{1'b0, PHASE_C, PHASE_A};
      default: r = '{keep: 1'b1, high: PHASE_NONE, low: PHASE_NONE};
    endcase
    return r;
  endfunction

endpackage

// ===== design/bcsl_event_unit.sv =====
// Event stage: commutation, tacho and hall counters, stall window and PID
// products. Depends on bcsl_pkg.
module bcsl_event_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  bcsl_pkg::req_e  req_i,
  input  logic [2:0]      hall_i,
  input  bcsl_pkg::cfg_t  cfg_i,
  output bcsl_pkg::pid_t  pid_o
);

  logic [15:0]        pulse_q, pulse_d;
  logic [15:0]        hall_cnt_q, hall_cnt_d;
  logic [15:0]        hall_seen_q, hall_seen_d;
  logic [3:0]         tick_q, tick_d;
  logic               stall_q, stall_d;
  logic [1:0]         high_q, high_d;
  logic [1:0]         low_q, low_d;
  bcsl_pkg::err_t     err1_q, err1_d;
  bcsl_pkg::err_t     err2_q, err2_d;
  bcsl_pkg::err_t     err_now;
  bcsl_pkg::drive_t   drive;
  bcsl_pkg::pid_t     pid_q, pid_d;

  always_comb begin
    pulse_d     = pulse_q;
    hall_cnt_d  = hall_cnt_q;
    hall_seen_d = hall_seen_q;
    tick_d      = tick_q;
    stall_d     = stall_q;
    high_d      = high_q;
    low_d       = low_q;
    err1_d      = err1_q;
    err2_d      = err2_q;
    err_now     = $signed({9'd0, cfg_i.target}) - $signed({1'b0, pulse_q});
    drive       = bcsl_pkg::drive_lookup(cfg_i.direction, hall_i);

    unique case (req_i)
      bcsl_pkg::REQ_TACHO: begin
        // saturate at full scale
        if (pulse_q != 16'hFFFF) pulse_d = pulse_q + 16'd1;
      end
      bcsl_pkg::REQ_HALL: begin
        hall_cnt_d = hall_cnt_q + 16'd1;
        if (!drive.keep) begin
          high_d = drive.high;
          low_d  = drive.low;
        end
      end
      bcsl_pkg::REQ_TICK: begin
        err2_d  = err1_q;
        err1_d  = err_now;
        pulse_d = '0;
        if (tick_q >= bcsl_pkg::STALL_LAST) begin
          if (hall_cnt_q == hall_seen_q) begin
            stall_d = 1'b1;
          end else begin
            hall_seen_d = hall_cnt_q;
            stall_d     = 1'b0;
          end
          tick_d = '0;
        end else begin
          tick_d = tick_q + 4'd1;
        end
        // compare the count as it stood before this tick
        if (hall_cnt_q > bcsl_pkg::HALL_WRAP) hall_cnt_d = '0;
      end
      default: ;
    endcase

    pid_d.tick   = (req_i == bcsl_pkg::REQ_TICK);
    pid_d.prod_p = bcsl_pkg::prod_t'(cfg_i.gain_p) * bcsl_pkg::prod_t'(err_now);
    pid_d.prod_i = bcsl_pkg::prod_t'(cfg_i.gain_i) * bcsl_pkg::prod_t'(err1_q);
    pid_d.prod_d = bcsl_pkg::prod_t'(cfg_i.gain_d) * bcsl_pkg::prod_t'(err2_q);
    pid_d.high   = high_d;
    pid_d.low    = low_d;
    pid_d.stall  = stall_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q     <= '0;
      hall_cnt_q  <= '0;
      hall_seen_q <= '0;
      tick_q      <= '0;
      stall_q     <= 1'b0;
      high_q      <= bcsl_pkg::PHASE_NONE;
      low_q       <= bcsl_pkg::PHASE_NONE;
      err1_q      <= '0;
      err2_q      <= '0;
    end else if (adv_i) begin
      pulse_q     <= pulse_d;
      hall_cnt_q  <= hall_cnt_d;
      hall_seen_q <= hall_seen_d;
      tick_q      <= tick_d;
      stall_q     <= stall_d;
      high_q      <= high_d;
      low_q       <= low_d;
      err1_q      <= err1_d;
      err2_q      <= err2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) pid_q <= pid_d;
  end

  assign pid_o = pid_q;

endmodule

// ===== design/bcsl_duty_unit.sv =====
// Duty stage: combines the PID products (P - I + D), scales to integer, accumulates and
// clamps the duty. Depends on bcsl_pkg.
module bcsl_duty_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  bcsl_pkg::pid_t pid_i,
  output logic [7:0]     duty_o
);

  logic [7:0]     duty_q;
  logic [7:0]     duty_clamp;
  bcsl_pkg::sum_t sum, sum_adj, corr, total;

  always_comb begin
    sum = bcsl_pkg::sum_t'(pid_i.prod_p) - bcsl_pkg::sum_t'(pid_i.prod_i)
        + bcsl_pkg::sum_t'(pid_i.prod_d);
    // bias negative sums so the shift truncates toward zero
    sum_adj = sum + (sum[bcsl_pkg::SUM_W-1] ?
                     bcsl_pkg::sum_t'(bcsl_pkg::FRAC_MASK) : bcsl_pkg::sum_t'(0));
    corr  = sum_adj >>> bcsl_pkg::FRAC_BITS;
    total = corr + bcsl_pkg::sum_t'({1'b0, duty_q});
    priority if (total[bcsl_pkg::SUM_W-1]) begin
      duty_clamp = '0;
    end else if (|total[bcsl_pkg::SUM_W-2:8]) begin
      duty_clamp = bcsl_pkg::DUTY_MAX;
    end else begin
      duty_clamp = total[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
    end else if (adv_i && pid_i.tick) begin
      duty_q <= duty_clamp;
    end
  end

  assign duty_o = pid_i.tick ? duty_clamp : duty_q;

endmodule

// ===== design/bldc_commutation_speed_loop_unit.sv =====
// Sensored BLDC commutation and incremental PID speed loop. Takes one event
// (tacho pulse, hall change or control tick) per cycle while results are
// taken, and returns one result per event with the drive state after it. Each
// event passes the input register, loaded at the transfer in, then the event
// stage register with the PID products, then the result register; a result
// not taken stalls the stages behind it. Throughput is one event per clock
// while results are taken, set by the state update in the event stage.
// Configure only while no event is in flight.
// Depends on bcsl_pkg, bcsl_event_unit and bcsl_duty_unit.
module bldc_commutation_speed_loop_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         req_type_i,
  input  logic [2:0]                         hall_state_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         high_side_phase_o,
  output logic [1:0]                         low_side_phase_o,
  output logic [7:0]                         duty_compare_o,
  output logic                               stall_flag_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bcsl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bcsl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  bcsl_pkg::cfg_t  cfg_q;
  logic            s1_vld_q, s2_vld_q, out_vld_q;
  bcsl_pkg::req_e  req_q;
  logic [2:0]      hall_q;
  logic            s1_fire, s2_fire, in_fire, cfg_fire;
  bcsl_pkg::pid_t  pid;
  logic [7:0]      duty_nxt;
  logic [1:0]      high_q, low_q;
  logic [7:0]      cmp_q;
  logic            stall_q;

  assign s2_fire    = s2_vld_q && (!out_vld_q || out_ready_i);
  assign s1_fire    = s1_vld_q && (!s2_vld_q || s2_fire);
  assign in_ready_o = !s1_vld_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= bcsl_pkg::TARGET_RST;
      cfg_q.gain_p    <= bcsl_pkg::GAIN_P_RST;
      cfg_q.gain_i    <= bcsl_pkg::GAIN_I_RST;
      cfg_q.gain_d    <= bcsl_pkg::GAIN_D_RST;
      cfg_q.direction <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        bcsl_pkg::CFG_TARGET:    cfg_q.target    <= cfg_data_i[7:0];
        bcsl_pkg::CFG_GAIN_P:    cfg_q.gain_p    <= $signed(cfg_data_i);
        bcsl_pkg::CFG_GAIN_I:    cfg_q.gain_i    <= $signed(cfg_data_i);
        bcsl_pkg::CFG_GAIN_D:    cfg_q.gain_d    <= $signed(cfg_data_i);
        bcsl_pkg::CFG_DIRECTION: cfg_q.direction <= cfg_data_i[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire)       s1_vld_q <= 1'b1;
      else if (s1_fire)  s1_vld_q <= 1'b0;
      if (s1_fire)       s2_vld_q <= 1'b1;
      else if (s2_fire)  s2_vld_q <= 1'b0;
      if (s2_fire)       out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q  <= bcsl_pkg::req_e'(req_type_i);
      hall_q <= hall_state_i;
    end
    if (s2_fire) begin
      high_q  <= pid.high;
      low_q   <= pid.low;
      cmp_q   <= bcsl_pkg::DUTY_MAX - duty_nxt;
      stall_q <= pid.stall;
    end
  end

  bcsl_event_unit u_event (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_fire),
    .req_i  (req_q),
    .hall_i (hall_q),
    .cfg_i  (cfg_q),
    .pid_o  (pid)
  );

  bcsl_duty_unit u_duty (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s2_fire),
    .pid_i  (pid),
    .duty_o (duty_nxt)
  );

  assign out_valid_o       = out_vld_q;
  assign high_side_phase_o = high_q;
  assign low_side_phase_o  = low_q;
  assign duty_compare_o    = cmp_q;
  assign stall_flag_o      = stall_q;

`ifndef NO_ASSERTIONS
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_vld_q)
    else $error("transfer in did not reach the event stage");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_fire |=> s1_vld_q && $stable(req_q) && $stable(hall_q))
    else $error("stalled event stage lost its item");

  a_drive_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((high_side_phase_o == bcsl_pkg::PHASE_NONE)
                     == (low_side_phase_o == bcsl_pkg::PHASE_NONE)))
    else $error("only one side of the bridge driven");

  a_no_shoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (high_side_phase_o != bcsl_pkg::PHASE_NONE)
      |-> (high_side_phase_o != low_side_phase_o))
    else $error("high and low side on the same phase");
`endif

endmodule
